>>> sv/dcs_pkg.sv
// Shared types, codes and width constants for the complex diagonal sparse matrix-vector unit.
`timescale 1ns / 1ps

package dcs_pkg;

    localparam int DEF_MAX_LENGTH = 4096;
    localparam int DEF_MAX_DIAGS  = 32;

    localparam int CMD_W    = 2;
    localparam int INDEX_W  = 12;
    localparam int DIAG_W   = 5;
    localparam int OFFSET_W = 13;
    localparam int VALUE_W  = 32;
    localparam int LEN_W    = 13;
    localparam int Y_W      = 48;
    localparam int PROD_W   = 64;
    localparam int TERM_W   = 49;
    localparam int ACC_W    = 56;

    // Width that holds any column, index or table bound for the full parameter range.
    localparam int CMP_W      = 18;
    localparam int DIAG_CMP_W = 9;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [CMD_W-1:0] CMD_LOAD_X   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_OFF = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MAC      = 2'd2;

    localparam logic [LEN_W-1:0] LEN_RESET = 13'd4096;

    typedef enum logic [1:0] {
        OP_LOAD_X,
        OP_LOAD_OFF,
        OP_MAC
    } op_t;

    typedef struct packed {
        op_t                        op;
        logic                       diag_ok;
        logic [INDEX_W-1:0]         index;
        logic [DIAG_W-1:0]          diag;
        logic signed [OFFSET_W-1:0] offset_value;
        logic signed [VALUE_W-1:0]  value_re;
        logic signed [VALUE_W-1:0]  value_im;
        logic                       last;
    } item_t;

endpackage

>>> sv/dcs_if.sv
// Valid/ready channel interfaces for the input and result beats.
`timescale 1ns / 1ps

interface dcs_in_if;
    import dcs_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [CMD_W-1:0]           cmd;
    logic [INDEX_W-1:0]         index;
    logic [DIAG_W-1:0]          diag;
    logic signed [OFFSET_W-1:0] offset_value;
    logic signed [VALUE_W-1:0]  value_re;
    logic signed [VALUE_W-1:0]  value_im;
    logic                       last;

    modport source (
        output valid, cmd, index, diag, offset_value, value_re, value_im, last,
        input  ready
    );
    modport sink (
        input  valid, cmd, index, diag, offset_value, value_re, value_im, last,
        output ready
    );
endinterface

interface dcs_out_if;
    import dcs_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [INDEX_W-1:0]    row;
    logic signed [Y_W-1:0] y_re;
    logic signed [Y_W-1:0] y_im;
    logic                  saturated;

    modport source (
        output valid, row, y_re, y_im, saturated,
        input  ready
    );
    modport sink (
        input  valid, row, y_re, y_im, saturated,
        output ready
    );
endinterface

>>> sv/dcs_front.sv
// Input stage that accepts beats, classifies them and drops those that change nothing.
`timescale 1ns / 1ps

module dcs_front #(
    parameter int MAX_LENGTH = dcs_pkg::DEF_MAX_LENGTH,
    parameter int MAX_DIAGS  = dcs_pkg::DEF_MAX_DIAGS
) (
    input  logic           clk,
    input  logic           rst_n,
    dcs_in_if.sink         in_ch,
    output logic           enq_valid,
    input  logic           enq_ready,
    output dcs_pkg::item_t enq_item
);
    import dcs_pkg::*;

    logic       valid_reg;
    item_t      item_reg;
    logic       take;
    logic       keep;
    logic       idx_ok;
    logic       diag_ok;
    item_t      item_next;

    assign in_ch.ready = !valid_reg || enq_ready;
    assign take        = in_ch.valid && in_ch.ready;
    assign enq_valid   = valid_reg;
    assign enq_item    = item_reg;

    assign idx_ok  = {{(CMP_W-INDEX_W){1'b0}}, in_ch.index} < CMP_W'(MAX_LENGTH);
    assign diag_ok = {{(DIAG_CMP_W-DIAG_W){1'b0}}, in_ch.diag} < DIAG_CMP_W'(MAX_DIAGS);

    always_comb
    begin
        item_next.op           = OP_MAC;
        item_next.diag_ok      = diag_ok;
        item_next.index        = in_ch.index;
        item_next.diag         = in_ch.diag;
        item_next.offset_value = in_ch.offset_value;
        item_next.value_re     = in_ch.value_re;
        item_next.value_im     = in_ch.value_im;
        item_next.last         = in_ch.last;
        keep                   = 1'b0;
        unique case (in_ch.cmd)
            CMD_LOAD_X:
            begin
                item_next.op = OP_LOAD_X;
                keep         = idx_ok;
            end
            CMD_LOAD_OFF:
            begin
                item_next.op = OP_LOAD_OFF;
                keep         = diag_ok;
            end
            CMD_MAC:
            begin
                item_next.op = OP_MAC;
                keep         = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            item_reg  <= '0;
        end
        else if (in_ch.ready)
        begin
            valid_reg <= take && keep;
            if (take)
            begin
                item_reg <= item_next;
            end
        end
    end

endmodule

>>> sv/dcs_queue.sv
// Short first-in first-out queue of classified items between the front and back.
`timescale 1ns / 1ps

module dcs_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           enq_valid,
    output logic           enq_ready,
    input  dcs_pkg::item_t enq_item,
    output logic           deq_valid,
    input  logic           deq_ready,
    output dcs_pkg::item_t deq_item
);
    import dcs_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t             q_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              push;
    logic              pop;

    assign enq_ready = count_reg != CNT_W'(QUEUE_DEPTH);
    assign deq_valid = count_reg != '0;
    assign deq_item  = q_mem[rd_ptr_reg];
    assign push      = enq_valid && enq_ready;
    assign pop       = deq_valid && deq_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= enq_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> sv/dcs_back.sv
// Execution sequencer with the vector and offset memories, the complex multiplier and accumulators.
`timescale 1ns / 1ps

module dcs_back #(
    parameter int MAX_LENGTH = dcs_pkg::DEF_MAX_LENGTH,
    parameter int MAX_DIAGS  = dcs_pkg::DEF_MAX_DIAGS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [dcs_pkg::LEN_W-1:0] vector_length,
    input  logic                      deq_valid,
    output logic                      deq_ready,
    input  dcs_pkg::item_t            deq_item,
    dcs_out_if.source                 out_ch
);
    import dcs_pkg::*;

    localparam int XAW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam int DAW = (MAX_DIAGS > 1) ? $clog2(MAX_DIAGS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COL,
        S_MUL,
        S_SUM,
        S_ACC
    } state_t;

    logic signed [VALUE_W-1:0]  xr_mem  [MAX_LENGTH];
    logic signed [VALUE_W-1:0]  xi_mem  [MAX_LENGTH];
    logic signed [OFFSET_W-1:0] off_mem [MAX_DIAGS];

    state_t                     state_reg;
    item_t                      cur_reg;
    logic signed [OFFSET_W-1:0] off_q_reg;
    logic signed [VALUE_W-1:0]  xr_q_reg;
    logic signed [VALUE_W-1:0]  xi_q_reg;
    logic signed [PROD_W-1:0]   p_rr_reg;
    logic signed [PROD_W-1:0]   p_ii_reg;
    logic signed [PROD_W-1:0]   p_ri_reg;
    logic signed [PROD_W-1:0]   p_ir_reg;
    logic signed [TERM_W-1:0]   term_re_reg;
    logic signed [TERM_W-1:0]   term_im_reg;
    logic signed [ACC_W-1:0]    acc_re_reg;
    logic signed [ACC_W-1:0]    acc_im_reg;
    logic                       acc_clip_reg;
    logic                       out_valid_reg;
    logic [INDEX_W-1:0]         row_reg;
    logic signed [Y_W-1:0]      y_re_reg;
    logic signed [Y_W-1:0]      y_im_reg;
    logic                       sat_reg;

    logic                       pop;
    logic [DAW-1:0]             head_diag_addr;
    logic [DIAG_CMP_W-1:0]      head_diag_ext;
    logic [CMP_W-1:0]           head_idx_ext;
    logic [XAW-1:0]             head_x_addr;
    logic signed [CMP_W-1:0]    col_s;
    logic [CMP_W-1:0]           vl_ext;
    logic [CMP_W-1:0]           max_ext;
    logic [CMP_W-1:0]           lim;
    logic                       col_ok;
    logic [XAW-1:0]             col_addr;
    logic                       x_rd;
    logic                       off_rd;
    logic                       out_free;
    logic                       emit;
    logic signed [ACC_W:0]      sum_re;
    logic signed [ACC_W:0]      sum_im;
    logic signed [ACC_W-1:0]    acc_re_next;
    logic signed [ACC_W-1:0]    acc_im_next;
    logic                       acc_sat_re;
    logic                       acc_sat_im;
    logic signed [Y_W-1:0]      y_re_next;
    logic signed [Y_W-1:0]      y_im_next;
    logic                       clip_re;
    logic                       clip_im;

    assign deq_ready = state_reg == S_IDLE;
    assign pop       = deq_valid && deq_ready;

    assign head_diag_ext  = {{(DIAG_CMP_W-DIAG_W){1'b0}}, deq_item.diag};
    assign head_diag_addr = head_diag_ext[DAW-1:0];
    assign head_idx_ext   = {{(CMP_W-INDEX_W){1'b0}}, deq_item.index};
    assign head_x_addr    = head_idx_ext[XAW-1:0];

    assign col_s    = $signed({{(CMP_W-INDEX_W){1'b0}}, cur_reg.index}) + CMP_W'(off_q_reg);
    assign vl_ext   = {{(CMP_W-LEN_W){1'b0}}, vector_length};
    assign max_ext  = CMP_W'(MAX_LENGTH);
    assign lim      = (vl_ext < max_ext) ? vl_ext : max_ext;
    assign col_ok   = !col_s[CMP_W-1] && ($unsigned(col_s) < lim);
    assign col_addr = col_s[XAW-1:0];

    assign off_rd = pop && (deq_item.op == OP_MAC) && deq_item.diag_ok;
    assign x_rd   = (state_reg == S_COL) && col_ok;

    always_ff @(posedge clk)
    begin
        if (pop && (deq_item.op == OP_LOAD_X))
        begin
            xr_mem[head_x_addr] <= deq_item.value_re;
            xi_mem[head_x_addr] <= deq_item.value_im;
        end
        if (x_rd)
        begin
            xr_q_reg <= xr_mem[col_addr];
            xi_q_reg <= xi_mem[col_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && (deq_item.op == OP_LOAD_OFF))
        begin
            off_mem[head_diag_addr] <= deq_item.offset_value;
        end
        if (off_rd)
        begin
            off_q_reg <= off_mem[head_diag_addr];
        end
    end

    assign sum_re = $signed({{(ACC_W+1-TERM_W){term_re_reg[TERM_W-1]}}, term_re_reg})
                  + $signed({acc_re_reg[ACC_W-1], acc_re_reg});
    assign sum_im = $signed({{(ACC_W+1-TERM_W){term_im_reg[TERM_W-1]}}, term_im_reg})
                  + $signed({acc_im_reg[ACC_W-1], acc_im_reg});

    always_comb
    begin
        acc_sat_re  = sum_re[ACC_W] != sum_re[ACC_W-1];
        acc_sat_im  = sum_im[ACC_W] != sum_im[ACC_W-1];
        acc_re_next = acc_sat_re ? {sum_re[ACC_W], {(ACC_W-1){!sum_re[ACC_W]}}}
                                 : sum_re[ACC_W-1:0];
        acc_im_next = acc_sat_im ? {sum_im[ACC_W], {(ACC_W-1){!sum_im[ACC_W]}}}
                                 : sum_im[ACC_W-1:0];
        clip_re     = acc_re_next[ACC_W-1:Y_W-1] != {(ACC_W-Y_W+1){acc_re_next[ACC_W-1]}};
        clip_im     = acc_im_next[ACC_W-1:Y_W-1] != {(ACC_W-Y_W+1){acc_im_next[ACC_W-1]}};
        y_re_next   = clip_re ? {acc_re_next[ACC_W-1], {(Y_W-1){!acc_re_next[ACC_W-1]}}}
                              : acc_re_next[Y_W-1:0];
        y_im_next   = clip_im ? {acc_im_next[ACC_W-1], {(Y_W-1){!acc_im_next[ACC_W-1]}}}
                              : acc_im_next[Y_W-1:0];
    end

    assign out_free = !out_valid_reg || out_ch.ready;
    assign emit     = (state_reg == S_ACC) && cur_reg.last && out_free;

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.row       = row_reg;
    assign out_ch.y_re      = y_re_reg;
    assign out_ch.y_im      = y_im_reg;
    assign out_ch.saturated = sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_reg       <= '0;
            p_rr_reg      <= '0;
            p_ii_reg      <= '0;
            p_ri_reg      <= '0;
            p_ir_reg      <= '0;
            term_re_reg   <= '0;
            term_im_reg   <= '0;
            acc_re_reg    <= '0;
            acc_im_reg    <= '0;
            acc_clip_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            row_reg       <= '0;
            y_re_reg      <= '0;
            y_im_reg      <= '0;
            sat_reg       <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (pop)
                    begin
                        cur_reg <= deq_item;
                        if (deq_item.op == OP_MAC)
                        begin
                            term_re_reg <= '0;
                            term_im_reg <= '0;
                            state_reg   <= deq_item.diag_ok ? S_COL : S_ACC;
                        end
                    end
                end
                S_COL:
                begin
                    state_reg <= col_ok ? S_MUL : S_ACC;
                end
                S_MUL:
                begin
                    p_rr_reg  <= cur_reg.value_re * xr_q_reg;
                    p_ii_reg  <= cur_reg.value_im * xi_q_reg;
                    p_ri_reg  <= cur_reg.value_re * xi_q_reg;
                    p_ir_reg  <= cur_reg.value_im * xr_q_reg;
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    // Dropping the low sixteen bits of each product floors it to Q.16.
                    term_re_reg <= $signed({p_rr_reg[PROD_W-1], p_rr_reg[PROD_W-1:16]})
                                 - $signed({p_ii_reg[PROD_W-1], p_ii_reg[PROD_W-1:16]});
                    term_im_reg <= $signed({p_ri_reg[PROD_W-1], p_ri_reg[PROD_W-1:16]})
                                 + $signed({p_ir_reg[PROD_W-1], p_ir_reg[PROD_W-1:16]});
                    state_reg   <= S_ACC;
                end
                S_ACC:
                begin
                    if (!cur_reg.last)
                    begin
                        acc_re_reg   <= acc_re_next;
                        acc_im_reg   <= acc_im_next;
                        acc_clip_reg <= acc_clip_reg || acc_sat_re || acc_sat_im;
                        state_reg    <= S_IDLE;
                    end
                    else if (out_free)
                    begin
                        row_reg       <= cur_reg.index;
                        y_re_reg      <= y_re_next;
                        y_im_reg      <= y_im_next;
                        sat_reg       <= acc_clip_reg || acc_sat_re || acc_sat_im
                                         || clip_re || clip_im;
                        acc_re_reg    <= '0;
                        acc_im_reg    <= '0;
                        acc_clip_reg  <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> sv/dia_complex_spmv.sv
// Top level of the complex sparse matrix-vector unit in diagonal storage.
//
//  Channel   Direction  Beat contents
//  in_ch     input      cmd, index, diag, offset_value, value_re, value_im, last
//  out_ch    output     row, y_re, y_im, saturated
//  cfg       input      vector_length, written when cfg_wr_en is high
//
// A load beat is written as the sequencer takes it. A coefficient beat passes offset read,
// vector read, multiply, combine and accumulate when its column is in range, skips multiply and
// combine when it is out of range and goes to accumulate when its diagonal is outside the table; a last
// beat also waits until the output register is free. Beats pass through a front register and a
// four-entry queue, so the input keeps accepting while the sequencer works until those fill.
// Reset clears the control state and the accumulators; the memories hold nothing until loaded.
`timescale 1ns / 1ps

module dia_complex_spmv #(
    parameter int MAX_LENGTH = dcs_pkg::DEF_MAX_LENGTH,
    parameter int MAX_DIAGS  = dcs_pkg::DEF_MAX_DIAGS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [dcs_pkg::LEN_W-1:0] cfg_wr_data,
    dcs_in_if.sink                    in_ch,
    dcs_out_if.source                 out_ch
);
    import dcs_pkg::*;

    logic [LEN_W-1:0] vector_length_reg;
    logic             enq_valid;
    logic             enq_ready;
    item_t            enq_item;
    logic             deq_valid;
    logic             deq_ready;
    item_t            deq_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vector_length_reg <= LEN_RESET;
        end
        else if (cfg_wr_en)
        begin
            vector_length_reg <= cfg_wr_data;
        end
    end

    dcs_front #(
        .MAX_LENGTH (MAX_LENGTH),
        .MAX_DIAGS  (MAX_DIAGS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .enq_valid (enq_valid),
        .enq_ready (enq_ready),
        .enq_item  (enq_item)
    );

    dcs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .enq_valid (enq_valid),
        .enq_ready (enq_ready),
        .enq_item  (enq_item),
        .deq_valid (deq_valid),
        .deq_ready (deq_ready),
        .deq_item  (deq_item)
    );

    dcs_back #(
        .MAX_LENGTH (MAX_LENGTH),
        .MAX_DIAGS  (MAX_DIAGS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .vector_length (vector_length_reg),
        .deq_valid     (deq_valid),
        .deq_ready     (deq_ready),
        .deq_item      (deq_item),
        .out_ch        (out_ch)
    );

endmodule
